// File: hw/rtl/kmd_pkg.sv
// kmd_pkg: shared constants and types for the k-way merge / dedup block.
// No dependencies; imported by kmd_seen and kway_merge_dedup_by_key_top.
package kmd_pkg;

  localparam int SOURCES   = 5;
  localparam int KEY_SPACE = 65536;

  localparam int KEY_W  = 16;
  localparam int SRC_W  = 3;
  localparam int SIDX_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;

  // seen bitmap organized as rows of ROW_W bits
  localparam int ROW_W     = 16;
  localparam int BIT_W     = $clog2(ROW_W);
  localparam int IDX_W     = $clog2(KEY_SPACE);
  localparam int SEEN_ROWS = (KEY_SPACE + ROW_W - 1) / ROW_W;
  localparam int ROW_AW    = (SEEN_ROWS > 1) ? $clog2(SEEN_ROWS) : 1;

  localparam bit KEY_IN_SPACE = (KEY_SPACE >= (2 ** KEY_W));
  localparam logic [KEY_W-1:0] KEY_SPACE_K = KEY_W'(KEY_SPACE % (2 ** KEY_W));
  localparam logic [ROW_AW-1:0] LAST_ROW   = ROW_AW'(SEEN_ROWS - 1);

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_KEY_LIMIT = '0;
  localparam logic [KEY_W-1:0]  KEY_LIMIT_RST = '1;

  // input kind codes
  localparam logic FUNC_HEAD = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_AW-1:0] rd_row;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_row;
    logic [ROW_W-1:0]  wr_data;
  } seen_req_t;

endpackage

// File: hw/rtl/kmd_seen.sv
// kmd_seen: seen-key bitmap memory, registered read, one write port.
// Runs a clearing sweep after reset. Depends on kmd_pkg.
module kmd_seen import kmd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  seen_req_t        req,
  output logic [ROW_W-1:0] rd_data,
  output logic             clearing
);

  logic [ROW_W-1:0]  mem [SEEN_ROWS];
  logic [ROW_W-1:0]  rd_data_r;
  logic              clr_r, clr_nxt;
  logic [ROW_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  always_comb begin
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    if (clr_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST_ROW) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_row];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_r;

endmodule

// File: hw/rtl/kway_merge_dedup_by_key_top.sv
// kway_merge_dedup_by_key_top: k-way merge of sorted keyed streams with
// duplicate removal. Depends on kmd_pkg and kmd_seen.
//
//  channel  dir   handshake              content
//  in_*     in    tvalid/tready          tuser=func, tdata=source,key
//  out_*    out   tvalid/tready          tuser=done_res, tdata=winner,key,flags
//  cfg_*    in    APB psel/penable       key_limit at byte address 0
//
// One transaction per cycle sustained when the output does not stall and no
// clearing runs. Heads sit in flops; the smallest is picked by a compare chain
// at accept. The seen-bitmap read-modify-write is done in the lookup stage (one
// memory read port, write-back forwarded); results then enter the output
// register. After reset a clearing sweep of all SEEN_ROWS (4096) rows holds
// in_tready low. A stalled output register stalls lookup and then in_tready.
module kway_merge_dedup_by_key_top import kmd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // [2:0] source, [18:3] key, [23:19] zero
  input  logic              in_tuser,   // [0] func
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // [2:0] winner, [18:3] winner_key,
                                        // [19] first_seen, [20] out_of_range,
                                        // [23:21] zero
  output logic              out_tuser,  // [0] done_res
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // configuration
  logic [KEY_W-1:0] key_limit_r;
  logic             cfg_sel_key;

  assign cfg_sel_key = (cfg_paddr[CFG_AW-1:2] == REG_KEY_LIMIT);
  assign cfg_pready  = 1'b1;
  assign cfg_prdata  = cfg_sel_key ? CFG_DW'(key_limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_limit_r <= KEY_LIMIT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_key) begin
      key_limit_r <= cfg_pwdata[KEY_W-1:0];
    end
  end

  // input fields
  logic             in_func;
  logic [SRC_W-1:0] in_src;
  logic [KEY_W-1:0] in_key;

  assign in_func = in_tuser;
  assign in_src  = in_tdata[SRC_W-1:0];
  assign in_key  = in_tdata[SRC_W +: KEY_W];

  // head state
  logic [KEY_W-1:0]   hk_r [SOURCES];
  logic [SOURCES-1:0] hp_r, he_r;
  logic               fin_r;

  logic [KEY_W-1:0]   hk_upd [SOURCES];
  logic [SOURCES-1:0] hp_upd, he_upd, hp_nxt;
  logic [SIDX_W-1:0]  src_idx, best;
  logic               src_ok, all_ready, any_head;

  // pipeline control
  logic in_acc, s0_live, s0_res, s0_done, s0_merge;
  logic clearing;
  logic s1_valid_r, s1_fire;

  assign in_acc   = in_tvalid && in_tready;
  assign s0_live  = in_acc && !fin_r;
  assign s0_res   = s0_live && all_ready;
  assign s0_done  = s0_res && !any_head;
  assign s0_merge = s0_res && any_head;

  assign src_ok  = (int'(in_src) < SOURCES);
  assign src_idx = SIDX_W'(in_src);

  always_comb begin
    hk_upd    = hk_r;
    hp_upd    = hp_r;
    he_upd    = he_r;
    all_ready = 1'b1;
    any_head  = 1'b0;
    best      = '0;
    if (src_ok) begin
      if (in_func == FUNC_END) begin
        he_upd[src_idx] = 1'b1;
      end else if (!he_r[src_idx]) begin
        hk_upd[src_idx] = in_key;
        hp_upd[src_idx] = 1'b1;
      end
    end
    for (int i = 0; i < SOURCES; i++) begin
      if (!hp_upd[i] && !he_upd[i]) begin
        all_ready = 1'b0;
      end
      if (hp_upd[i]) begin
        if (!any_head || (hk_upd[i] < hk_upd[best])) begin
          best = SIDX_W'(i);
        end
        any_head = 1'b1;
      end
    end
    hp_nxt = hp_upd;
    if (s0_merge) begin
      hp_nxt[best] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r  <= '0;
      he_r  <= '0;
      fin_r <= 1'b0;
      for (int i = 0; i < SOURCES; i++) begin
        hk_r[i] <= '0;
      end
    end else if (s0_live) begin
      hk_r <= hk_upd;
      hp_r <= hp_nxt;
      he_r <= he_upd;
      if (s0_done) begin
        fin_r <= 1'b1;
      end
    end
  end

  // winner key and bitmap address
  logic [KEY_W-1:0]  win_key;
  logic              win_oor;
  logic [IDX_W-1:0]  win_idx;
  logic [ROW_AW-1:0] win_row;
  logic [BIT_W-1:0]  win_bit;

  assign win_key = hk_upd[best];
  assign win_oor = (win_key > key_limit_r) || (!KEY_IN_SPACE && (win_key >= KEY_SPACE_K));
  assign win_idx = IDX_W'(win_key);
  assign win_row = ROW_AW'(win_idx >> BIT_W);
  assign win_bit = win_idx[BIT_W-1:0];

  // lookup stage
  logic              s1_done_r, s1_oor_r, s1_fwd_r;
  logic [SRC_W-1:0]  s1_win_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic [ROW_AW-1:0] s1_row_r;
  logic [BIT_W-1:0]  s1_bit_r;
  logic [ROW_W-1:0]  fwd_data_r;
  logic [ROW_W-1:0]  rd_data, s1_row_data, s1_row_set;
  logic              s1_first, s1_wr;
  seen_req_t         seen_req;

  logic              out_valid_r;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clearing && (!s1_valid_r || s1_fire);

  assign s1_row_data = s1_fwd_r ? fwd_data_r : rd_data;
  assign s1_first    = !s1_done_r && !s1_oor_r && !s1_row_data[s1_bit_r];
  assign s1_row_set  = s1_row_data | (ROW_W'(1) << s1_bit_r);
  assign s1_wr       = s1_fire && s1_first;

  assign seen_req.rd_en   = s0_merge;
  assign seen_req.rd_row  = win_row;
  assign seen_req.wr_en   = s1_wr;
  assign seen_req.wr_row  = s1_row_r;
  assign seen_req.wr_data = s1_row_set;

  kmd_seen u_seen (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (seen_req),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s0_res) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_res) begin
      s1_done_r <= s0_done;
      s1_oor_r  <= s0_merge && win_oor;
      s1_win_r  <= s0_done ? '0 : SRC_W'(best);
      s1_key_r  <= s0_done ? '0 : win_key;
      s1_row_r  <= win_row;
      s1_bit_r  <= win_bit;
      s1_fwd_r  <= s1_wr && (s1_row_r == win_row);
    end
    if (s1_wr) begin
      fwd_data_r <= s1_row_set;
    end
  end

  // output register
  logic             out_done_r, out_first_r, out_oor_r;
  logic [SRC_W-1:0] out_win_r;
  logic [KEY_W-1:0] out_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_done_r  <= s1_done_r;
      out_first_r <= s1_first;
      out_oor_r   <= s1_oor_r;
      out_win_r   <= s1_win_r;
      out_key_r   <= s1_key_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_done_r;
  assign out_tdata  = {3'b000, out_oor_r, out_first_r, out_key_r, out_win_r};

endmodule

// File: tb/sv/kmd_merge_checker.sv
`timescale 1ns / 100ps
// kmd_merge_checker: watches the input, result and configuration channels of
// kway_merge_dedup_by_key_top, predicts each merge result and compares it.
// Depends on kmd_pkg only.
module kmd_merge_checker import kmd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [23:0]       in_tdata,   // [2:0] source, [18:3] key, [23:19] zero
  input  logic              in_tuser,   // [0] func
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [23:0]       out_tdata,  // [2:0] winner, [18:3] winner_key,
                                        // [19] first_seen, [20] out_of_range
  input  logic              out_tuser,  // [0] done_res
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic [CFG_DW-1:0] cfg_prdata,
  input  logic              cfg_pready,
  output int                pending,
  output int                errors
);

  typedef struct packed {
    logic [SRC_W-1:0] winner;
    logic [KEY_W-1:0] winner_key;
    logic             first_seen;
    logic             out_of_range;
    logic             done_res;
  } merge_res_t;

  merge_res_t       merge_q[$];
  logic [KEY_W-1:0] key_limit;
  logic [KEY_W-1:0] head_key [SOURCES];
  bit               head_valid [SOURCES];
  bit               src_ended [SOURCES];
  bit               seen [KEY_SPACE];
  bit               merge_over;

  task automatic merge_step(input logic func, input logic [SRC_W-1:0] src,
                            input logic [KEY_W-1:0] key);
    bit               all_ready;
    bit               any_head;
    int               best;
    logic [KEY_W-1:0] k;
    merge_res_t       res;
    all_ready = 1'b1;
    any_head  = 1'b0;
    best      = 0;
    if (!merge_over) begin
      if (int'(src) < SOURCES) begin
        if (func == FUNC_END) begin
          src_ended[src] = 1'b1;
        end else if (!src_ended[src]) begin
          head_key[src]   = key;
          head_valid[src] = 1'b1;
        end
      end
      for (int i = 0; i < SOURCES; i++) begin
        if (!head_valid[i] && !src_ended[i]) all_ready = 1'b0;
        if (head_valid[i]) begin
          if (!any_head || head_key[i] < head_key[best]) best = i;
          any_head = 1'b1;
        end
      end
      if (all_ready) begin
        res = '0;
        if (!any_head) begin
          merge_over   = 1'b1;
          res.done_res = 1'b1;
        end else begin
          k = head_key[best];
          head_valid[best] = 1'b0;
          res.winner     = SRC_W'(best);
          res.winner_key = k;
          if (k > key_limit || int'(k) >= KEY_SPACE) begin
            res.out_of_range = 1'b1;
          end else if (!seen[k]) begin
            res.first_seen = 1'b1;
            seen[k] = 1'b1;
          end
        end
        merge_q.push_back(res);
      end
    end
  endtask

  task automatic check_result();
    merge_res_t want;
    merge_res_t got;
    got = {out_tdata[2:0], out_tdata[18:3], out_tdata[19], out_tdata[20], out_tuser};
    if (merge_q.size() == 0) begin
      $error("unexpected result: winner %0d key %0d done %0b",
             got.winner, got.winner_key, got.done_res);
      errors++;
    end else begin
      want = merge_q.pop_front();
      if (got.winner !== want.winner) begin
        $error("winner: expected %0d, got %0d", want.winner, got.winner);
        errors++;
      end
      if (got.winner_key !== want.winner_key) begin
        $error("winner_key: expected %0d, got %0d", want.winner_key, got.winner_key);
        errors++;
      end
      if (got.first_seen !== want.first_seen) begin
        $error("first_seen: expected %0b, got %0b", want.first_seen, got.first_seen);
        errors++;
      end
      if (got.out_of_range !== want.out_of_range) begin
        $error("out_of_range: expected %0b, got %0b", want.out_of_range,
               got.out_of_range);
        errors++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      merge_q.delete();
      key_limit  = KEY_LIMIT_RST;
      merge_over = 1'b0;
      for (int i = 0; i < SOURCES; i++) begin
        head_key[i]   = '0;
        head_valid[i] = 1'b0;
        src_ended[i]  = 1'b0;
      end
      foreach (seen[i]) seen[i] = 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        merge_step(in_tuser, in_tdata[2:0], in_tdata[18:3]);
      if (out_tvalid && out_tready)
        check_result();
      if (cfg_psel && cfg_penable && cfg_pready &&
          cfg_paddr[CFG_AW-1:2] == REG_KEY_LIMIT) begin
        if (cfg_pwrite) begin
          key_limit = cfg_pwdata[KEY_W-1:0];
        end else if (cfg_prdata !== CFG_DW'(key_limit)) begin
          $error("key_limit: expected %0d, got %0d", key_limit, cfg_prdata);
          errors++;
        end
      end
    end
    pending <= merge_q.size();
  end

endmodule

// File: tb/sv/kway_merge_dedup_by_key_top_tb.sv
`timescale 1ns / 100ps
// kway_merge_dedup_by_key_top_tb: drives mostly sorted keyed streams with stray
// keys, ignored sources, source ends and key_limit settings; kmd_merge_checker
// judges results. Depends on kmd_pkg, kway_merge_dedup_by_key_top and kmd_merge_checker.
module kway_merge_dedup_by_key_top_tb;
  import kmd_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 190;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [23:0]       out_tdata;
  logic              out_tuser;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                pending;
  int                errors;

  int snd_idle = 0;
  int rcv_stall = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet = 0;

  // stream state seen from the sending side, used to keep sequences well formed
  logic [KEY_W-1:0] strm_key [SOURCES];
  bit               strm_held [SOURCES];
  bit               strm_ended [SOURCES];
  bit               strm_over = 1'b0;
  int               next_key [SOURCES];

  kway_merge_dedup_by_key_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  kmd_merge_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .pending(pending), .errors(errors)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("kway_merge_dedup_by_key_top_tb: done, errors");
      $finish;
    end
  end

  task automatic cfg_access(input bit wr, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {REG_KEY_LIMIT, 2'b00};
    cfg_pwdata  <= data;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic track(input logic func, input logic [SRC_W-1:0] src,
                       input logic [KEY_W-1:0] key);
    bit ready;
    bit any_head;
    int best;
    ready    = 1'b1;
    any_head = 1'b0;
    best     = 0;
    if (!strm_over) begin
      if (int'(src) < SOURCES) begin
        if (func == FUNC_END) begin
          strm_ended[src] = 1'b1;
        end else if (!strm_ended[src]) begin
          strm_key[src]  = key;
          strm_held[src] = 1'b1;
        end
      end
      for (int i = 0; i < SOURCES; i++) begin
        if (!strm_held[i] && !strm_ended[i]) ready = 1'b0;
        if (strm_held[i]) begin
          if (!any_head || strm_key[i] < strm_key[best]) best = i;
          any_head = 1'b1;
        end
      end
      if (ready && !any_head) strm_over = 1'b1;
      else if (ready) strm_held[best] = 1'b0;
    end
  endtask

  task automatic send_item(input logic func, input logic [SRC_W-1:0] src,
                           input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {5'b0, key, src};
    do @(posedge clk); while (!in_tready);
    track(func, src, key);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic settle();
    drain();
    repeat (4) @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    int s;
    int off;
    r = $urandom_range(99);
    if (r < 8) begin
      send_item(1'($urandom_range(1)), SRC_W'($urandom_range(7, SOURCES)),
                KEY_W'($urandom));
    end else if (r < 14) begin
      send_item(FUNC_HEAD, SRC_W'($urandom_range(SOURCES - 1)), KEY_W'($urandom));
    end else begin
      off = $urandom_range(SOURCES - 1);
      s   = off;
      for (int i = 0; i < SOURCES; i++) begin
        if (!strm_held[(off + i) % SOURCES] && !strm_ended[(off + i) % SOURCES]) begin
          s = (off + i) % SOURCES;
          break;
        end
      end
      send_item(FUNC_HEAD, SRC_W'(s), KEY_W'(next_key[s]));
      if (next_key[s] < 65530) next_key[s] += $urandom_range(3);
    end
  endtask

  initial begin
    int limit;
    int base;
    for (int i = 0; i < SOURCES; i++) begin
      strm_key[i]   = '0;
      strm_held[i]  = 1'b0;
      strm_ended[i] = 1'b0;
      next_key[i]   = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    cfg_access(1'b1, 40000);
    cfg_access(1'b0, 0);

    // directed: extremes, ties, replacement, ignored sources, limit edge
    send_item(FUNC_HEAD, 3'd5, 16'hFFFF);
    send_item(FUNC_END,  3'd7, 16'h0000);
    send_item(FUNC_HEAD, 3'd6, 16'h5555);
    send_item(FUNC_HEAD, 3'd0, 16'd0);
    send_item(FUNC_HEAD, 3'd1, 16'hFFFF);
    send_item(FUNC_HEAD, 3'd2, 16'd40000);
    send_item(FUNC_HEAD, 3'd3, 16'd40001);
    send_item(FUNC_HEAD, 3'd4, 16'd0);
    send_item(FUNC_HEAD, 3'd0, 16'd0);
    send_item(FUNC_HEAD, 3'd1, 16'hAAAA);
    send_item(FUNC_HEAD, 3'd0, 16'd40000);
    send_item(FUNC_HEAD, 3'd4, 16'd40000);
    send_item(FUNC_HEAD, 3'd7, 16'h1234);
    send_item(FUNC_HEAD, 3'd0, 16'd39999);
    send_item(FUNC_HEAD, 3'd1, 16'd1);
    send_item(FUNC_HEAD, 3'd2, 16'd2);
    send_item(FUNC_HEAD, 3'd3, 16'd40000);
    send_item(FUNC_HEAD, 3'd4, 16'h7FFF);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin snd_idle = 0;  rcv_stall = 0;  limit = 65535; base = 0;     end
        1: begin snd_idle = 53; rcv_stall = 0;  limit = 0;     base = 0;     end
        2: begin snd_idle = 0;  rcv_stall = 53; limit = 150;   base = 100;   end
        default: begin
          snd_idle = 17; rcv_stall = 17; limit = 62000; base = 61800;
        end
      endcase
      cfg_access(1'b1, limit);
      cfg_access(1'b0, 0);
      for (int i = 0; i < SOURCES; i++) next_key[i] = base + $urandom_range(8);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 60) hold_req = 1'b1;
        if (ph == 2 && n == 95) drain();
        random_item();
      end
    end

    // wind down: end every source, feed keys to ended ones, flush heads to done, send stray items
    for (int s = 0; s < SOURCES; s++) begin
      send_item(FUNC_END, SRC_W'(s), KEY_W'($urandom));
      send_item(FUNC_HEAD, SRC_W'(s), KEY_W'($urandom));
    end
    while (!strm_over)
      send_item(FUNC_END, SRC_W'($urandom_range(SOURCES - 1)), '0);
    repeat (3) send_item(1'($urandom_range(1)), SRC_W'($urandom_range(7)),
                         KEY_W'($urandom));

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("kway_merge_dedup_by_key_top_tb: done, clean");
    else
      $display("kway_merge_dedup_by_key_top_tb: done, errors");
    $finish;
  end

endmodule
